/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

/* sv/tcsm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP connection state machine package
// State, flag, event and command codes, result type and transition table.
// ---------------------------------------------------------------------------
package tcsm_pkg;

    typedef logic [3:0] t_state;
    typedef logic [7:0] t_flags;
    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_note;
    typedef logic [3:0] t_event;

    localparam t_state S_CLOSED     = 4'd0;
    localparam t_state S_SYN_SENT   = 4'd1;
    localparam t_state S_SYN_RCVD   = 4'd2;
    localparam t_state S_LISTEN     = 4'd3;
    localparam t_state S_ESTAB      = 4'd4;
    localparam t_state S_FIN_WAIT1  = 4'd5;
    localparam t_state S_FIN_WAIT2  = 4'd6;
    localparam t_state S_TIME_WAIT  = 4'd7;
    localparam t_state S_CLOSING    = 4'd8;
    localparam t_state S_CLOSE_WAIT = 4'd9;
    localparam t_state S_LAST_ACK   = 4'd10;

    localparam t_flags FL_NONE = 8'h00;
    localparam t_flags FL_FIN  = 8'h01;
    localparam t_flags FL_SYN  = 8'h02;
    localparam t_flags FL_RST  = 8'h04;
    localparam t_flags FL_ACK  = 8'h10;

    localparam t_note NOTE_NONE = 2'd0;
    localparam t_note NOTE_OK   = 2'd1;
    localparam t_note NOTE_EOF  = 2'd2;

    localparam t_cmd CMD_SEG     = 3'd0;
    localparam t_cmd CMD_AOPEN   = 3'd1;
    localparam t_cmd CMD_POPEN   = 3'd2;
    localparam t_cmd CMD_CLOSE   = 3'd3;
    localparam t_cmd CMD_TIMEOUT = 3'd4;
    localparam t_cmd CMD_ABORT   = 3'd5;
    // unused codes, ignored with the state held
    localparam t_cmd CMD_SPARE0  = 3'd6;
    localparam t_cmd CMD_SPARE1  = 3'd7;

    localparam t_event EV_ACK     = 4'd0;
    localparam t_event EV_SYN     = 4'd1;
    localparam t_event EV_FIN     = 4'd2;
    localparam t_event EV_RST     = 4'd3;
    localparam t_event EV_SYNACK  = 4'd4;
    localparam t_event EV_FINACK  = 4'd5;
    localparam t_event EV_NONE    = 4'd6;
    localparam t_event EV_BAD     = 4'd7;
    localparam t_event EV_AOPEN   = 4'd8;
    localparam t_event EV_POPEN   = 4'd9;
    localparam t_event EV_CLOSE   = 4'd10;
    localparam t_event EV_TIMEOUT = 4'd11;

    typedef struct packed {
        t_state next_state;
        t_flags send_flags;
        t_note  close_notice;
        logic   connected;
        logic   listening;
        logic   failed;
    } t_result;

    typedef struct packed {
        logic    hit;
        t_result res;
    } t_move;

    function automatic t_event classify(input t_flags f);
        t_event ev;
        case (f)
            FL_ACK:          ev = EV_ACK;
            FL_SYN:          ev = EV_SYN;
            FL_FIN:          ev = EV_FIN;
            FL_RST:          ev = EV_RST;
            FL_SYN | FL_ACK: ev = EV_SYNACK;
            FL_FIN | FL_ACK: ev = EV_FINACK;
            FL_NONE:         ev = EV_NONE;
            default:         ev = EV_BAD;
        endcase
        return ev;
    endfunction

    function automatic t_event cmd_event(input t_cmd c);
        t_event ev;
        case (c)
            CMD_AOPEN:   ev = EV_AOPEN;
            CMD_POPEN:   ev = EV_POPEN;
            CMD_CLOSE:   ev = EV_CLOSE;
            CMD_TIMEOUT: ev = EV_TIMEOUT;
            default:     ev = EV_BAD;
        endcase
        return ev;
    endfunction

    function automatic t_move mv(input t_state nxt, input t_flags snd, input t_note note);
        t_move m;
        m = '0;
        m.hit = 1'b1;
        m.res.next_state = nxt;
        m.res.send_flags = snd;
        m.res.close_notice = note;
        return m;
    endfunction

    // Table lookup; hit is low when the pair has no entry.
    function automatic t_move lookup(input t_state st, input t_event ev);
        t_move m;
        m = '0;
        case (st)
            S_CLOSED: begin
                if (ev == EV_AOPEN) m = mv(S_SYN_SENT, FL_SYN, NOTE_NONE);
                else if (ev == EV_POPEN) begin
                    m = mv(S_LISTEN, FL_NONE, NOTE_NONE);
                    m.res.listening = 1'b1;
                end
            end
            S_SYN_SENT: begin
                if (ev == EV_CLOSE) m = mv(S_CLOSED, FL_NONE, NOTE_NONE);
                else if (ev == EV_SYN) m = mv(S_SYN_RCVD, FL_ACK, NOTE_NONE);
                else if (ev == EV_SYNACK) begin
                    m = mv(S_ESTAB, FL_ACK, NOTE_NONE);
                    m.res.connected = 1'b1;
                end
            end
            S_LISTEN: begin
                if (ev == EV_CLOSE) m = mv(S_CLOSED, FL_NONE, NOTE_OK);
                else if (ev == EV_SYN) m = mv(S_SYN_RCVD, FL_SYN | FL_ACK, NOTE_NONE);
            end
            S_SYN_RCVD: begin
                if (ev == EV_ACK) m = mv(S_ESTAB, FL_NONE, NOTE_NONE);
            end
            S_ESTAB: begin
                if (ev == EV_CLOSE) m = mv(S_FIN_WAIT1, FL_FIN, NOTE_NONE);
                else if (ev == EV_FIN) m = mv(S_CLOSE_WAIT, FL_ACK, NOTE_NONE);
                else if (ev == EV_NONE || ev == EV_ACK) m = mv(S_ESTAB, FL_NONE, NOTE_NONE);
            end
            S_FIN_WAIT1: begin
                if (ev == EV_FIN) m = mv(S_CLOSING, FL_ACK, NOTE_NONE);
                else if (ev == EV_FINACK) m = mv(S_TIME_WAIT, FL_ACK, NOTE_NONE);
                else if (ev == EV_ACK) m = mv(S_FIN_WAIT2, FL_NONE, NOTE_OK);
                else if (ev == EV_NONE) m = mv(S_FIN_WAIT1, FL_NONE, NOTE_NONE);
            end
            S_FIN_WAIT2: begin
                if (ev == EV_FIN) m = mv(S_TIME_WAIT, FL_ACK, NOTE_NONE);
                else if (ev == EV_NONE) m = mv(S_FIN_WAIT2, FL_NONE, NOTE_NONE);
            end
            S_CLOSE_WAIT: begin
                if (ev == EV_CLOSE) m = mv(S_LAST_ACK, FL_FIN, NOTE_NONE);
                else if (ev == EV_ACK) m = mv(S_CLOSE_WAIT, FL_NONE, NOTE_NONE);
            end
            S_CLOSING: begin
                if (ev == EV_ACK) m = mv(S_TIME_WAIT, FL_NONE, NOTE_NONE);
            end
            S_TIME_WAIT: begin
                if (ev == EV_TIMEOUT) m = mv(S_CLOSED, FL_NONE, NOTE_EOF);
            end
            S_LAST_ACK: begin
                if (ev == EV_ACK) m = mv(S_CLOSED, FL_NONE, NOTE_OK);
            end
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* sv/tcsm_cmd_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP state machine event channel
// Valid/ready channel carrying one command and received flag byte.
// ---------------------------------------------------------------------------
interface tcsm_cmd_if import tcsm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_flags seg_flags;

    modport source (output valid, output cmd, output seg_flags, input ready);
    modport sink   (input valid, input cmd, input seg_flags, output ready);
endinterface

/* sv/tcsm_res_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP state machine result channel
// Valid/ready channel carrying one transition result.
// ---------------------------------------------------------------------------
interface tcsm_res_if import tcsm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_state next_state;
    t_flags send_flags;
    t_note  close_notice;
    logic   connected;
    logic   listening;
    logic   failed;

    modport source (output valid, output next_state, output send_flags,
                    output close_notice, output connected, output listening,
                    output failed, input ready);
    modport sink   (input valid, input next_state, input send_flags,
                    input close_notice, input connected, input listening,
                    input failed, output ready);
endinterface

/* sv/tcp_connection_state_machine_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TCP connection state machine core
// Tracks one connection through the eleven TCP states, one event per transfer.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  i_cmd    | in  | valid/ready     | cmd, seg_flags
//  o_res    | out | valid/ready     | next_state, send_flags, close_notice,
//           |     |                 | connected, listening, failed
//  cfg      | in  | i_cfg_wr_en     | i_cfg_wr_data (start_in_listen)
//
// One event per cycle sustained while the output does not stall. Each event
// is looked up from the input register and its result registered for output.
// Reset is synchronous: state returns to CLOSED, both stages empty.
// A stalled output holds its result and the input register holds one more
// event; input ready drops only while both are full and the output stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcp_connection_state_machine_core import tcsm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    tcsm_cmd_if.sink   i_cmd,
    tcsm_res_if.source o_res
);

    logic    r_in_valid;
    t_cmd    r_cmd;
    t_flags  r_flags;
    logic    r_out_valid;
    t_result r_res;
    t_state  r_state;

    t_result n_res;
    t_state  n_state;
    t_move   w_move;
    t_event  w_event;
    logic    w_adv;
    logic    w_step;

    assign w_adv  = !r_out_valid || o_res.ready;
    assign w_step = r_in_valid && w_adv;
    assign i_cmd.ready = !r_in_valid || w_adv;

    always_comb begin
        w_event = (r_cmd == CMD_SEG) ? classify(r_flags) : cmd_event(r_cmd);
        w_move  = lookup(r_state, w_event);
        n_res   = '0;
        n_res.next_state = r_state;
        if (r_cmd == CMD_ABORT) begin
            n_res.next_state = S_CLOSED;
        end else if (r_cmd inside {[CMD_SEG:CMD_TIMEOUT]}) begin
            if (w_move.hit) begin
                n_res = w_move.res;
            end else begin
                // no entry: reset the peer and drop to CLOSED
                n_res.next_state = S_CLOSED;
                n_res.send_flags = FL_RST;
                n_res.failed     = 1'b1;
            end
        end
        n_state = i_cfg_wr_en ? (i_cfg_wr_data ? S_LISTEN : S_CLOSED) : n_res.next_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= S_CLOSED;
        end else begin
            if (i_cmd.ready) r_in_valid <= i_cmd.valid;
            if (w_adv) r_out_valid <= r_in_valid;
            if (i_cfg_wr_en || w_step) r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd   <= i_cmd.cmd;
            r_flags <= i_cmd.seg_flags;
        end
        if (w_step) r_res <= n_res;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.next_state   = r_res.next_state;
    assign o_res.send_flags   = r_res.send_flags;
    assign o_res.close_notice = r_res.close_notice;
    assign o_res.connected    = r_res.connected;
    assign o_res.listening    = r_res.listening;
    assign o_res.failed       = r_res.failed;

    `ASSERT_CLK(a_state_follows_result, i_clk, i_rst_n,
        (w_step && !i_cfg_wr_en) |=> (r_state == r_res.next_state))
    `ASSERT_CLK(a_fail_sends_rst, i_clk, i_rst_n,
        (o_res.valid && o_res.failed) |->
        (o_res.next_state == S_CLOSED && o_res.send_flags == FL_RST))
    `ASSERT_CLK(a_connect_is_estab, i_clk, i_rst_n,
        (o_res.valid && o_res.connected) |-> (o_res.next_state == S_ESTAB && !o_res.failed))
    `ASSERT_CLK(a_held_input_stable, i_clk, i_rst_n,
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_cmd) && $stable(r_flags)))

endmodule
